// ===== rtl/nlm_pkg.sv =====
`default_nettype none
package nlm_pkg;

  // default geometry
  localparam int WINDOW_RADIUS_DEF   = 2;
  localparam int NEIGHBOR_RADIUS_DEF = 1;
  localparam int MAX_WIDTH_DEF       = 1024;
  localparam int PIXEL_BITS_DEF      = 16;

  // fixed field widths
  localparam int IW_W       = 11;
  localparam int IH_W       = 13;
  localparam int INV_W      = 24;
  localparam int ROW_W      = 13;
  localparam int MAX_HEIGHT = 4096;
  localparam int D_W        = 24;
  localparam int X_W        = D_W + INV_W;
  localparam int IDX_SHIFT  = 20;
  localparam int EXP_N      = 256;
  localparam int WGT_W      = 17;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [D_W-1:0] D_MAX = {D_W{1'b1}};

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_INV_SIGMA_SQ = 2'd2;

  localparam logic [IW_W-1:0]  IMAGE_WIDTH_RST  = 11'd1024;
  localparam logic [IH_W-1:0]  IMAGE_HEIGHT_RST = 13'd1024;
  localparam logic [INV_W-1:0] INV_SIGMA_SQ_RST = 24'd65536;

  typedef logic [EXP_N-1:0][WGT_W-1:0] exp_arr_t;

  // exp(-i/16) in q1.16, built by repeated multiplication in q32.32
  function automatic exp_arr_t build_exp();
    exp_arr_t    t;
    logic [63:0] acc;
    logic [63:0] tmp;
    t[0] = 17'd65536;
    acc  = 64'd1 << 32;
    for (int i = 1; i < EXP_N; i++) begin
      acc  = (acc * 64'd2017374190 + (64'd1 << 30)) >> 31;
      tmp  = (acc + 64'd32768) >> 16;
      t[i] = tmp[WGT_W-1:0];
    end
    return t;
  endfunction

  localparam exp_arr_t EXP_TABLE = build_exp();

  typedef struct packed {
    logic accept;
    logic start;
    logic tap_sq;
    logic tap_acc;
    logic sqrt_init;
    logic sqrt_step;
    logic mul;
    logic lut;
    logic nd_acc;
    logic div_init;
    logic div_step;
    logic out_load;
  } nlm_cmd_t;

  typedef struct packed {
    logic emit;
  } nlm_sts_t;

endpackage
`default_nettype wire

// ===== rtl/nonlocal_means_denoise.sv =====
`default_nettype none
// channel  | dir | handshake              | payload
// s_axis   | in  | s_axis_tvalid/tready   | tdata: pixel[15:0]; tuser: frame_start
// m_axis   | out | m_axis_tvalid/tready   | tdata: filtered_pixel, out_x, out_y;
//          |     |                        | tlast: frame_end
// cfg      | in  | cfg_we (no wait)       | cfg_addr index, cfg_data value
//
// an item that yields a result is processed by one shared distance / root / weight unit;
//   SQRT_STEPS = (2*PIXEL_BITS + clog2((2N+1)^2) + 17) / 2 root iterations per position
// an item that yields no result is only written to the line store and the unit stays idle
// rst is synchronous; it clears counters and state machine, the line store is not cleared
// input is taken only while the unit is idle; a finished result waits in the output
// register and a new item is taken while it waits
module nonlocal_means_denoise #(
  parameter int WINDOW_RADIUS   = nlm_pkg::WINDOW_RADIUS_DEF,
  parameter int NEIGHBOR_RADIUS = nlm_pkg::NEIGHBOR_RADIUS_DEF,
  parameter int MAX_WIDTH       = nlm_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS      = nlm_pkg::PIXEL_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [15:0]                    s_axis_tdata,  // pixel[15:0]
  input  wire logic                           s_axis_tuser,  // frame_start
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // filtered_pixel[15:0], out_x[25:16], out_y[37:26], zero fill
  output logic [39:0]                         m_axis_tdata,
  output logic                                m_axis_tlast,
  input  wire logic                           cfg_we,
  input  wire logic [nlm_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [nlm_pkg::CFG_DATA_W-1:0] cfg_data
);
  localparam int PS_W = $clog2(2 * NEIGHBOR_RADIUS + 1);
  localparam int WS_W = $clog2(2 * WINDOW_RADIUS + 1);

  nlm_pkg::nlm_cmd_t cmd;
  nlm_pkg::nlm_sts_t sts;
  logic [PS_W-1:0]   a_idx, b_idx;
  logic [WS_W-1:0]   n_idx, m_idx;
  logic [15:0]       filtered_pixel;
  logic [9:0]        out_x;
  logic [11:0]       out_y;

  // sequencer: loops over search positions and patch taps
  nlm_ctrl #(
    .WINDOW_RADIUS   (WINDOW_RADIUS),
    .NEIGHBOR_RADIUS (NEIGHBOR_RADIUS),
    .PIXEL_BITS      (PIXEL_BITS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .sts     (sts),
    .cmd     (cmd),
    .a_idx   (a_idx),
    .b_idx   (b_idx),
    .n_idx   (n_idx),
    .m_idx   (m_idx)
  );

  // line store, raster counters and arithmetic
  nlm_dp #(
    .WINDOW_RADIUS   (WINDOW_RADIUS),
    .NEIGHBOR_RADIUS (NEIGHBOR_RADIUS),
    .MAX_WIDTH       (MAX_WIDTH),
    .PIXEL_BITS      (PIXEL_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .a_idx          (a_idx),
    .b_idx          (b_idx),
    .n_idx          (n_idx),
    .m_idx          (m_idx),
    .sts            (sts),
    .pixel          (s_axis_tdata),
    .frame_start    (s_axis_tuser),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_data       (cfg_data),
    .filtered_pixel (filtered_pixel),
    .out_x          (out_x),
    .out_y          (out_y),
    .frame_end      (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, out_y, out_x, filtered_pixel};
endmodule
`default_nettype wire

// ===== rtl/nlm_ram.sv =====
`default_nettype none
module nlm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] ra_addr,
  output logic      [WIDTH-1:0]         ra_data,
  input  wire logic [$clog2(DEPTH)-1:0] rb_addr,
  output logic      [WIDTH-1:0]         rb_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end
endmodule
`default_nettype wire

// ===== rtl/nlm_ctrl.sv =====
`default_nettype none
module nlm_ctrl #(
  parameter int WINDOW_RADIUS   = nlm_pkg::WINDOW_RADIUS_DEF,
  parameter int NEIGHBOR_RADIUS = nlm_pkg::NEIGHBOR_RADIUS_DEF,
  parameter int PIXEL_BITS      = nlm_pkg::PIXEL_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_valid,
  output logic                      s_ready,
  output logic                      m_valid,
  input  wire logic                 m_ready,
  input  wire nlm_pkg::nlm_sts_t    sts,
  output nlm_pkg::nlm_cmd_t         cmd,
  output logic [$clog2(2*NEIGHBOR_RADIUS+1)-1:0] a_idx,
  output logic [$clog2(2*NEIGHBOR_RADIUS+1)-1:0] b_idx,
  output logic [$clog2(2*WINDOW_RADIUS+1)-1:0]   n_idx,
  output logic [$clog2(2*WINDOW_RADIUS+1)-1:0]   m_idx
);
  localparam int PS       = 2 * NEIGHBOR_RADIUS + 1;
  localparam int WS       = 2 * WINDOW_RADIUS + 1;
  localparam int PS_W     = $clog2(PS);
  localparam int WS_W     = $clog2(WS);
  localparam int S_W      = 2 * PIXEL_BITS + $clog2(PS * PS);
  localparam int SQ_STEPS = (S_W + 16 + 1) / 2;
  localparam int Q_W      = PIXEL_BITS + 1;
  localparam int STP_MAX  = (SQ_STEPS > Q_W) ? SQ_STEPS : Q_W;
  localparam int STP_W    = $clog2(STP_MAX + 1);

  localparam logic [PS_W-1:0]  P_LAST  = PS_W'(PS - 1);
  localparam logic [WS_W-1:0]  W_LAST  = WS_W'(WS - 1);
  localparam logic [STP_W-1:0] SQ_LAST = STP_W'(SQ_STEPS - 1);
  localparam logic [STP_W-1:0] DV_LAST = STP_W'(Q_W - 1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_RD    = 4'd1;
  localparam logic [3:0] ST_SQ    = 4'd2;
  localparam logic [3:0] ST_ACC   = 4'd3;
  localparam logic [3:0] ST_SQRT0 = 4'd4;
  localparam logic [3:0] ST_SQRT  = 4'd5;
  localparam logic [3:0] ST_MUL   = 4'd6;
  localparam logic [3:0] ST_LUT   = 4'd7;
  localparam logic [3:0] ST_NDACC = 4'd8;
  localparam logic [3:0] ST_DIV0  = 4'd9;
  localparam logic [3:0] ST_DIV   = 4'd10;
  localparam logic [3:0] ST_DONE  = 4'd11;

  logic [3:0]       state;
  logic [STP_W-1:0] step;

  assign s_ready = (state == ST_IDLE);

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.accept = s_valid;
        cmd.start  = s_valid & sts.emit;
      end
      ST_SQ:    cmd.tap_sq    = 1'b1;
      ST_ACC:   cmd.tap_acc   = 1'b1;
      ST_SQRT0: cmd.sqrt_init = 1'b1;
      ST_SQRT:  cmd.sqrt_step = 1'b1;
      ST_MUL:   cmd.mul       = 1'b1;
      ST_LUT:   cmd.lut       = 1'b1;
      ST_NDACC: cmd.nd_acc    = 1'b1;
      ST_DIV0:  cmd.div_init  = 1'b1;
      ST_DIV:   cmd.div_step  = 1'b1;
      ST_DONE:  cmd.out_load  = ~m_valid | m_ready;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      step    <= '0;
      a_idx   <= '0;
      b_idx   <= '0;
      n_idx   <= '0;
      m_idx   <= '0;
      m_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd.start) begin
            a_idx <= '0;
            b_idx <= '0;
            n_idx <= '0;
            m_idx <= '0;
            state <= ST_RD;
          end
        end
        ST_RD:  state <= ST_SQ;
        ST_SQ:  state <= ST_ACC;
        ST_ACC: begin
          if (b_idx == P_LAST) begin
            b_idx <= '0;
            if (a_idx == P_LAST) begin
              a_idx <= '0;
              state <= ST_SQRT0;
            end else begin
              a_idx <= a_idx + 1'b1;
              state <= ST_RD;
            end
          end else begin
            b_idx <= b_idx + 1'b1;
            state <= ST_RD;
          end
        end
        ST_SQRT0: begin
          step  <= '0;
          state <= ST_SQRT;
        end
        ST_SQRT: begin
          step <= step + 1'b1;
          if (step == SQ_LAST) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: state <= ST_LUT;
        ST_LUT: state <= ST_NDACC;
        ST_NDACC: begin
          state <= ST_RD;
          if (m_idx == W_LAST) begin
            m_idx <= '0;
            if (n_idx == W_LAST) begin
              n_idx <= '0;
              state <= ST_DIV0;
            end else begin
              n_idx <= n_idx + 1'b1;
            end
          end else begin
            m_idx <= m_idx + 1'b1;
          end
        end
        ST_DIV0: begin
          step  <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          step <= step + 1'b1;
          if (step == DV_LAST) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (cmd.out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/nlm_dp.sv =====
`default_nettype none
module nlm_dp #(
  parameter int WINDOW_RADIUS   = nlm_pkg::WINDOW_RADIUS_DEF,
  parameter int NEIGHBOR_RADIUS = nlm_pkg::NEIGHBOR_RADIUS_DEF,
  parameter int MAX_WIDTH       = nlm_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS      = nlm_pkg::PIXEL_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire nlm_pkg::nlm_cmd_t                 cmd,
  input  wire logic [$clog2(2*NEIGHBOR_RADIUS+1)-1:0] a_idx,
  input  wire logic [$clog2(2*NEIGHBOR_RADIUS+1)-1:0] b_idx,
  input  wire logic [$clog2(2*WINDOW_RADIUS+1)-1:0]   n_idx,
  input  wire logic [$clog2(2*WINDOW_RADIUS+1)-1:0]   m_idx,
  output nlm_pkg::nlm_sts_t                      sts,
  input  wire logic [15:0]                       pixel,
  input  wire logic                              frame_start,
  input  wire logic                              cfg_we,
  input  wire logic [nlm_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [nlm_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic [15:0]                            filtered_pixel,
  output logic [9:0]                             out_x,
  output logic [11:0]                            out_y,
  output logic                                   frame_end
);
  localparam int TOT_R    = WINDOW_RADIUS + NEIGHBOR_RADIUS;
  localparam int SPAN     = 2 * TOT_R + 1;
  localparam int LINE_LEN = MAX_WIDTH + 2 * TOT_R;
  localparam int DEPTH    = SPAN * LINE_LEN;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int COL_W    = $clog2(LINE_LEN + 1);
  localparam int SLOT_W   = $clog2(SPAN);
  localparam int SL2_W    = SLOT_W + 1;
  localparam int ROW_W    = nlm_pkg::ROW_W;
  localparam int PS       = 2 * NEIGHBOR_RADIUS + 1;
  localparam int WS       = 2 * WINDOW_RADIUS + 1;
  localparam int PS_W     = $clog2(PS);
  localparam int PB       = PIXEL_BITS;
  localparam int S_W      = 2 * PB + $clog2(PS * PS);
  localparam int SQ_STEPS = (S_W + 16 + 1) / 2;
  localparam int V2_W     = 2 * SQ_STEPS;
  localparam int RM_W     = SQ_STEPS + 2;
  localparam int RT_W     = (SQ_STEPS > nlm_pkg::D_W) ? SQ_STEPS : nlm_pkg::D_W;
  localparam int WGT_W    = nlm_pkg::WGT_W;
  localparam int DEN_W    = WGT_W + $clog2(WS * WS);
  localparam int NUM_W    = DEN_W + PB + 1;
  localparam int Q_W      = PB + 1;
  localparam int X_W      = nlm_pkg::X_W;

  localparam logic [PS_W-1:0] CTR_TAP = PS_W'(NEIGHBOR_RADIUS);
  localparam logic [Q_W-1:0]  PIX_MAX = Q_W'((1 << PB) - 1);

  // configuration
  logic [nlm_pkg::IW_W-1:0]  image_width;
  logic [nlm_pkg::IH_W-1:0]  image_height;
  logic [nlm_pkg::INV_W-1:0] inv_sigma_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= nlm_pkg::IMAGE_WIDTH_RST;
      image_height <= nlm_pkg::IMAGE_HEIGHT_RST;
      inv_sigma_sq <= nlm_pkg::INV_SIGMA_SQ_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        nlm_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[nlm_pkg::IW_W-1:0];
        nlm_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[nlm_pkg::IH_W-1:0];
        nlm_pkg::REG_INV_SIGMA_SQ: inv_sigma_sq <= cfg_data[nlm_pkg::INV_W-1:0];
        default: ;
      endcase
    end
  end

  // raster position
  logic [15:0]       w_eff;
  logic [ROW_W-1:0]  h_eff;
  logic [COL_W-1:0]  pw;
  logic [ROW_W-1:0]  ph;
  logic [COL_W-1:0]  column_count, c0, col, col_inc;
  logic [ROW_W-1:0]  row_count, r0, row, row_inc;
  logic [SLOT_W-1:0] row_slot, s0, slot, slot_inc;
  logic [COL_W-1:0]  ox;
  logic [ROW_W-1:0]  oy;

  always_comb begin
    if (image_width == '0) begin
      w_eff = 16'd1;
    end else if (16'(image_width) > 16'(MAX_WIDTH)) begin
      w_eff = 16'(MAX_WIDTH);
    end else begin
      w_eff = 16'(image_width);
    end
    if (image_height == '0) begin
      h_eff = ROW_W'(1);
    end else if (image_height > ROW_W'(nlm_pkg::MAX_HEIGHT)) begin
      h_eff = ROW_W'(nlm_pkg::MAX_HEIGHT);
    end else begin
      h_eff = image_height;
    end
    pw = COL_W'(w_eff) + COL_W'(2 * TOT_R);
    ph = h_eff + ROW_W'(2 * TOT_R);

    c0 = frame_start ? '0 : column_count;
    r0 = frame_start ? '0 : row_count;
    s0 = frame_start ? '0 : row_slot;
    if (c0 >= pw) begin
      c0 = '0;
      r0 = r0 + 1'b1;
      s0 = (s0 == SLOT_W'(SPAN - 1)) ? '0 : s0 + 1'b1;
    end
    if (r0 >= ph) begin
      r0 = '0;
      s0 = '0;
    end
    col  = c0;
    row  = r0;
    slot = s0;

    col_inc  = col + 1'b1;
    row_inc  = row;
    slot_inc = slot;
    if (col_inc >= pw) begin
      col_inc  = '0;
      row_inc  = row + 1'b1;
      slot_inc = (slot == SLOT_W'(SPAN - 1)) ? '0 : slot + 1'b1;
      if (row_inc >= ph) begin
        row_inc  = '0;
        slot_inc = '0;
      end
    end
    ox = col - COL_W'(2 * TOT_R);
    oy = row - ROW_W'(2 * TOT_R);
  end

  assign sts.emit = (row >= ROW_W'(2 * TOT_R)) && (col >= COL_W'(2 * TOT_R));

  logic [COL_W-1:0]  x0;
  logic [SLOT_W-1:0] cur_slot;
  logic [9:0]        pos_x;
  logic [11:0]       pos_y;
  logic              pos_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      row_slot     <= '0;
    end else if (cmd.accept) begin
      column_count <= col_inc;
      row_count    <= row_inc;
      row_slot     <= slot_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x0       <= ox;
      cur_slot <= slot;
      pos_x    <= 10'(ox);
      pos_y    <= 12'(oy);
      pos_last <= (ox == COL_W'(w_eff - 16'd1)) && (oy == h_eff - 1'b1);
    end
  end

  // line store addressing
  logic [SL2_W-1:0]  sa_sum, sc_sum;
  logic [SLOT_W-1:0] sa, sc;
  logic [COL_W-1:0]  ca, cc;
  logic [ADDR_W-1:0] waddr, ra_addr, rb_addr;
  logic [PB-1:0]     ra_data, rb_data;

  always_comb begin
    sa_sum = SL2_W'(cur_slot) + SL2_W'(1) + SL2_W'(n_idx) + SL2_W'(a_idx);
    sc_sum = SL2_W'(cur_slot) + SL2_W'(1 + WINDOW_RADIUS) + SL2_W'(a_idx);
    sa = (sa_sum >= SL2_W'(SPAN)) ? SLOT_W'(sa_sum - SL2_W'(SPAN)) : SLOT_W'(sa_sum);
    sc = (sc_sum >= SL2_W'(SPAN)) ? SLOT_W'(sc_sum - SL2_W'(SPAN)) : SLOT_W'(sc_sum);
    ca = x0 + COL_W'(m_idx) + COL_W'(b_idx);
    cc = x0 + COL_W'(WINDOW_RADIUS) + COL_W'(b_idx);
    waddr   = ADDR_W'(slot) * ADDR_W'(LINE_LEN) + ADDR_W'(col);
    ra_addr = ADDR_W'(sa) * ADDR_W'(LINE_LEN) + ADDR_W'(ca);
    rb_addr = ADDR_W'(sc) * ADDR_W'(LINE_LEN) + ADDR_W'(cc);
  end

  nlm_ram #(
    .WIDTH (PB),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk     (clk),
    .we      (cmd.accept),
    .waddr   (waddr),
    .wdata   (pixel[PB-1:0]),
    .ra_addr (ra_addr),
    .ra_data (ra_data),
    .rb_addr (rb_addr),
    .rb_data (rb_data)
  );

  // patch distance, root, weight, weighted sums, divide
  logic [PB-1:0]      diff;
  logic [PB-1:0]      cpix;
  logic [2*PB-1:0]    sq;
  logic [S_W-1:0]     ssd;
  logic [V2_W-1:0]    vsh;
  logic [RM_W-1:0]    rem, rem_n, trial;
  logic [SQ_STEPS-1:0] root;
  logic [RT_W-1:0]    root_ext;
  logic [nlm_pkg::D_W-1:0] dist_sat;
  logic [X_W-1:0]     xprod;
  logic [WGT_W-1:0]   wgt;
  logic [NUM_W-1:0]   num, drem, dsh;
  logic [DEN_W-1:0]   den;
  logic [Q_W-1:0]     quo;

  always_comb begin
    sq       = diff * diff;
    rem_n    = {rem[RM_W-3:0], vsh[V2_W-1 -: 2]};
    trial    = {root, 2'b01};
    root_ext = RT_W'(root);
    dist_sat = (root_ext > RT_W'(nlm_pkg::D_MAX)) ? nlm_pkg::D_MAX
                                                   : root_ext[nlm_pkg::D_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ssd <= '0;
      num <= '0;
      den <= '0;
    end
    if (cmd.tap_sq) begin
      diff <= (ra_data >= rb_data) ? ra_data - rb_data : rb_data - ra_data;
      if (a_idx == CTR_TAP && b_idx == CTR_TAP) begin
        cpix <= ra_data;
      end
    end
    if (cmd.tap_acc) begin
      ssd <= ssd + S_W'(sq);
    end
    if (cmd.sqrt_init) begin
      vsh  <= V2_W'({ssd, 16'b0});
      rem  <= '0;
      root <= '0;
      ssd  <= '0;
    end
    if (cmd.sqrt_step) begin
      vsh <= {vsh[V2_W-3:0], 2'b00};
      if (rem_n >= trial) begin
        rem  <= rem_n - trial;
        root <= {root[SQ_STEPS-2:0], 1'b1};
      end else begin
        rem  <= rem_n;
        root <= {root[SQ_STEPS-2:0], 1'b0};
      end
    end
    if (cmd.mul) begin
      xprod <= X_W'(dist_sat) * X_W'(inv_sigma_sq);
    end
    if (cmd.lut) begin
      // index is distance times 1/sigma^2 in steps of 1/16
      wgt <= (xprod[X_W-1:nlm_pkg::IDX_SHIFT+8] == '0)
             ? nlm_pkg::EXP_TABLE[xprod[nlm_pkg::IDX_SHIFT+7:nlm_pkg::IDX_SHIFT]]
             : '0;
    end
    if (cmd.nd_acc) begin
      num <= num + NUM_W'(wgt) * NUM_W'(cpix);
      den <= den + DEN_W'(wgt);
    end
    if (cmd.div_init) begin
      drem <= num + NUM_W'(den >> 1);
      dsh  <= NUM_W'(den) << (Q_W - 1);
      quo  <= '0;
    end
    if (cmd.div_step) begin
      dsh <= dsh >> 1;
      if (drem >= dsh) begin
        drem <= drem - dsh;
        quo  <= {quo[Q_W-2:0], 1'b1};
      end else begin
        quo  <= {quo[Q_W-2:0], 1'b0};
      end
    end
    if (cmd.out_load) begin
      filtered_pixel <= 16'((quo > PIX_MAX) ? PIX_MAX : quo);
      out_x          <= pos_x;
      out_y          <= pos_y;
      frame_end      <= pos_last;
    end
  end
endmodule
`default_nettype wire
